// File: hdl/tfcm_pkg.sv
// tfcm_pkg: shared types and constants for the thermal false colour map
// used by tfcm_ctrl, tfcm_dp and thermal_false_colour_map; no dependencies
package tfcm_pkg;

    localparam int TEMP_W = 14;
    localparam int BP_W   = 30;        // breakpoints and v, Q16 temperatures
    localparam int DIFF_W = BP_W + 1;
    localparam int NUM_W  = DIFF_W + 9;
    localparam int REM_W  = 39;
    localparam int DSH_W  = 38;

    // span fractions in Q16
    localparam logic [15:0] FRAC_A = 16'd13900;
    localparam logic [15:0] FRAC_B = 16'd20854;
    localparam logic [15:0] FRAC_C = 16'd27800;
    localparam logic [15:0] FRAC_D = 16'd53622;

    localparam logic [7:0] TOP_FULL = 8'd255;
    localparam logic [7:0] TOP_BLUE = 8'd240;

    localparam logic signed [TEMP_W-1:0] LOW_RESET     = 14'sd4080;
    localparam logic signed [TEMP_W-1:0] HIGH_RESET    = 14'sd0;
    localparam logic signed [TEMP_W-1:0] SCALE_MIN_RST = 14'sd320;
    localparam logic signed [TEMP_W-1:0] SCALE_MAX_RST = 14'sd640;

    // register index taken from paddr[2]
    localparam logic REG_SCALE_MIN = 1'b0;
    localparam logic REG_SCALE_MAX = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BP,
        S_SETUP,
        S_MUL,
        S_NORM,
        S_DIV,
        S_STORE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef enum logic [1:0] {
        RAMP_DIV,
        RAMP_ZERO,
        RAMP_FULL
    } ramp_mode_t;

    typedef struct packed {
        logic       load;
        logic       bp_en;
        logic [1:0] bp_idx;
        chan_t      chan;
        logic       setup_en;
        logic       mul_en;
        logic       norm_en;
        logic       div_en;
        logic       store_en;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic quick;    // ramp resolved without division
    } status_t;

    function automatic logic [15:0] bp_frac(input logic [1:0] idx);
        logic [15:0] f;
        unique case (idx)
            2'd0:    f = FRAC_A;
            2'd1:    f = FRAC_B;
            2'd2:    f = FRAC_C;
            default: f = FRAC_D;
        endcase
        return f;
    endfunction

endpackage

// File: hdl/thermal_false_colour_map.sv
// thermal_false_colour_map: top level with APB scale registers
// depends on tfcm_pkg, tfcm_ctrl, tfcm_dp
//
// One pixel (1/16 degree units) is taken at a time and turned into an RGB565
// ironbow colour plus the frame's running minimum and maximum. A pixel occupies
// the block from accept to the next accept: an accept state, the breakpoint
// steps, then for each of red, green and blue the setup, multiply and normalise
// states, the shared eight-step restoring divider unless the ramp is flat or
// clamped, and a store state, then a handoff state. The result sits in an
// output register, so the next pixel is taken while it waits. Scale registers
// sit at byte address 0 (scale_min, reset 320) and 4 (scale_max, reset 640);
// the user must write them only while the block is idle; it is not enforced.
module thermal_false_colour_map (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [tfcm_pkg::TEMP_W-1:0] temperature,
    input  logic                               frame_start,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [15:0]                        colour,
    output logic signed [tfcm_pkg::TEMP_W-1:0] frame_low,
    output logic signed [tfcm_pkg::TEMP_W-1:0] frame_high
);
    import tfcm_pkg::*;

    logic signed [TEMP_W-1:0] scale_min_reg, scale_max_reg;
    logic                     wr_en;
    cmd_t                     cmd;
    status_t                  status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_min_reg <= SCALE_MIN_RST;
            scale_max_reg <= SCALE_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_SCALE_MIN: scale_min_reg <= pwdata[TEMP_W-1:0];
                default:       scale_max_reg <= pwdata[TEMP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SCALE_MIN: prdata = {{(32-TEMP_W){scale_min_reg[TEMP_W-1]}}, scale_min_reg};
            default:       prdata = {{(32-TEMP_W){scale_max_reg[TEMP_W-1]}}, scale_max_reg};
        endcase
    end

    tfcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tfcm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .scale_min   (scale_min_reg),
        .scale_max   (scale_max_reg),
        .temperature (temperature),
        .frame_start (frame_start),
        .colour      (colour),
        .frame_low   (frame_low),
        .frame_high  (frame_high)
    );

endmodule

// File: hdl/tfcm_ctrl.sv
// tfcm_ctrl: sequencer for breakpoints, per-channel ramps and result handoff
// depends on tfcm_pkg
module tfcm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tfcm_pkg::status_t status,
    output tfcm_pkg::cmd_t    cmd
);
    import tfcm_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    chan_t      ch_reg, ch_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_load;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_BP;
                    step_next  = 3'd0;
                end
            end
            S_BP:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = S_SETUP;
                    ch_next    = CH_RED;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_SETUP: state_next = S_MUL;
            S_MUL:   state_next = S_NORM;
            S_NORM:
            begin
                step_next  = 3'd0;
                state_next = status.quick ? S_STORE : S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                unique case (ch_reg)
                    CH_RED:
                    begin
                        ch_next    = CH_GREEN;
                        state_next = S_SETUP;
                    end
                    CH_GREEN:
                    begin
                        ch_next    = CH_BLUE;
                        state_next = S_SETUP;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        cmd          = '0;
        cmd.bp_idx   = step_reg[1:0];
        cmd.chan     = ch_reg;
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.bp_en    = (state_reg == S_BP);
        cmd.setup_en = (state_reg == S_SETUP);
        cmd.mul_en   = (state_reg == S_MUL);
        cmd.norm_en  = (state_reg == S_NORM);
        cmd.div_en   = (state_reg == S_DIV);
        cmd.store_en = (state_reg == S_STORE);
        cmd.out_load = out_load;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            ch_reg        <= CH_RED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a finished result waits while the output slot stays full
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result left done state while output slot full");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == 3'd7) |=> (state_reg == S_STORE))
        else $error("divider did not end after eight steps");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_BP && step_reg == 3'd0))
        else $error("accepted transfer did not start breakpoint pass");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result load did not raise out_valid");

endmodule

// File: hdl/tfcm_dp.sv
// tfcm_dp: breakpoints, ramp setup, multiply, restoring divide, min/max tracking
// depends on tfcm_pkg; driven by tfcm_ctrl commands
module tfcm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tfcm_pkg::cmd_t                      cmd,
    output tfcm_pkg::status_t                   status,
    input  logic signed [tfcm_pkg::TEMP_W-1:0]  scale_min,
    input  logic signed [tfcm_pkg::TEMP_W-1:0]  scale_max,
    input  logic signed [tfcm_pkg::TEMP_W-1:0]  temperature,
    input  logic                                frame_start,
    output logic [15:0]                         colour,
    output logic signed [tfcm_pkg::TEMP_W-1:0]  frame_low,
    output logic signed [tfcm_pkg::TEMP_W-1:0]  frame_high
);
    import tfcm_pkg::*;

    logic signed [TEMP_W-1:0] t_reg;
    logic signed [TEMP_W-1:0] run_low_reg, run_high_reg;
    logic signed [BP_W-1:0]   bp_reg [4];
    logic signed [DIFF_W-1:0] diff_reg, den_reg;
    logic [7:0]               top_reg;
    ramp_mode_t               mode_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DSH_W-1:0]         dsh_reg;
    logic [7:0]               q_reg;
    logic [7:0]               red_reg, green_reg, blue_reg;
    logic [15:0]              colour_reg;
    logic signed [TEMP_W-1:0] low_out_reg, high_out_reg;

    function automatic logic signed [DIFF_W-1:0] sub_bp(
        input logic signed [BP_W-1:0] a,
        input logic signed [BP_W-1:0] b
    );
        return $signed({a[BP_W-1], a}) - $signed({b[BP_W-1], b});
    endfunction

    // breakpoint: smin*2^16 + span*frac, always within the 30-bit range
    logic signed [TEMP_W:0]   span;
    logic signed [31:0]       bp_prod;
    logic signed [32:0]       bp_sum;
    logic signed [BP_W-1:0]   lo, hi, v;

    assign span    = $signed({scale_max[TEMP_W-1], scale_max})
                   - $signed({scale_min[TEMP_W-1], scale_min});
    assign bp_prod = $signed({{(32-TEMP_W-1){span[TEMP_W]}}, span})
                   * $signed({16'b0, bp_frac(cmd.bp_idx)});
    assign lo      = {scale_min, 16'b0};
    assign hi      = {scale_max, 16'b0};
    assign v       = {t_reg, 16'b0};
    assign bp_sum  = $signed({{3{lo[BP_W-1]}}, lo}) + $signed({bp_prod[31], bp_prod});

    // ramp selection per channel
    logic signed [BP_W-1:0]   pa, pb, pc, pd;
    logic signed [DIFF_W-1:0] diff_sel, den_sel;
    logic [7:0]               top_sel;
    ramp_mode_t               mode_sel;

    assign pa = bp_reg[0];
    assign pb = bp_reg[1];
    assign pc = bp_reg[2];
    assign pd = bp_reg[3];

    always_comb
    begin
        diff_sel = sub_bp(v, pb);
        den_sel  = sub_bp(pc, pb);
        top_sel  = TOP_FULL;
        mode_sel = RAMP_DIV;
        unique case (cmd.chan)
            CH_RED: ;
            CH_GREEN:
            begin
                priority if (v > lo && v < pa)
                begin
                    diff_sel = sub_bp(v, lo);
                    den_sel  = sub_bp(pa, lo);
                end
                else if (v >= pa && v <= pc)
                    mode_sel = RAMP_FULL;
                else if (v > pc)
                begin
                    diff_sel = sub_bp(v, pd);
                    den_sel  = sub_bp(pc, pd);
                end
                else
                    mode_sel = RAMP_ZERO;
            end
            default:
            begin
                priority if (v <= pb)
                begin
                    diff_sel = sub_bp(v, pb);
                    den_sel  = sub_bp(pa, pb);
                end
                else if (v <= pd)
                    mode_sel = RAMP_ZERO;
                else
                begin
                    diff_sel = sub_bp(v, pd);
                    den_sel  = sub_bp(hi, pd);
                    top_sel  = TOP_BLUE;
                end
            end
        endcase
    end

    // normalize sign, detect ramps that need no division
    logic signed [NUM_W-1:0]  num_pos;
    logic [DIFF_W-1:0]        den_abs;
    logic [REM_W:0]           den_sh8;
    logic                     n_le_zero, den_zero, over;
    logic [7:0]               q_fix;

    always_comb
    begin
        num_pos   = den_reg[DIFF_W-1] ? -num_reg : num_reg;
        den_abs   = den_reg[DIFF_W-1] ? DIFF_W'(-den_reg) : DIFF_W'(den_reg);
        den_sh8   = {1'b0, den_abs, 8'b0};
        den_zero  = (den_reg == '0);
        n_le_zero = num_pos[NUM_W-1] || (num_pos == '0);
        over      = ({1'b0, num_pos[REM_W-1:0]} >= den_sh8);
        q_fix     = 8'd0;
        status.quick = 1'b1;
        priority if (mode_reg == RAMP_ZERO)
            q_fix = 8'd0;
        else if (mode_reg == RAMP_FULL)
            q_fix = TOP_FULL;
        else if (den_zero || n_le_zero)
            q_fix = 8'd0;
        else if (over)
            q_fix = top_reg;
        else
            status.quick = 1'b0;
    end

    logic [7:0] q_clamped;
    assign q_clamped = (q_reg > top_reg) ? top_reg : q_reg;

    // min/max fold of the pixel being accepted
    logic signed [TEMP_W-1:0] base_low, base_high, new_low, new_high;
    assign base_low  = frame_start ? LOW_RESET : run_low_reg;
    assign base_high = frame_start ? HIGH_RESET : run_high_reg;
    assign new_low   = (temperature < base_low) ? temperature : base_low;
    assign new_high  = (temperature > base_high) ? temperature : base_high;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_low_reg  <= LOW_RESET;
            run_high_reg <= HIGH_RESET;
        end
        else if (cmd.load)
        begin
            run_low_reg  <= new_low;
            run_high_reg <= new_high;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            t_reg <= temperature;
        if (cmd.bp_en)
            bp_reg[cmd.bp_idx] <= bp_sum[BP_W-1:0];
        if (cmd.setup_en)
        begin
            diff_reg <= diff_sel;
            den_reg  <= den_sel;
            top_reg  <= top_sel;
            mode_reg <= mode_sel;
        end
        if (cmd.mul_en)
            num_reg <= $signed({{(NUM_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg})
                     * $signed({{(NUM_W-8){1'b0}}, top_reg});
        if (cmd.norm_en)
        begin
            q_reg   <= q_fix;
            rem_reg <= num_pos[REM_W-1:0];
            dsh_reg <= {den_abs, 7'b0};
        end
        if (cmd.div_en)
        begin
            if (rem_reg >= {1'b0, dsh_reg})
            begin
                rem_reg <= rem_reg - {1'b0, dsh_reg};
                q_reg   <= {q_reg[6:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[6:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.store_en)
        begin
            unique case (cmd.chan)
                CH_RED:   red_reg   <= q_clamped;
                CH_GREEN: green_reg <= q_clamped;
                default:  blue_reg  <= q_clamped;
            endcase
        end
        if (cmd.out_load)
        begin
            colour_reg   <= {red_reg[7:3], green_reg[7:2], blue_reg[7:3]};
            low_out_reg  <= run_low_reg;
            high_out_reg <= run_high_reg;
        end
    end

    assign colour     = colour_reg;
    assign frame_low  = low_out_reg;
    assign frame_high = high_out_reg;

    a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_low_reg <= LOW_RESET)
        else $error("running minimum above its frame start value");

    a_high_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_high_reg >= HIGH_RESET)
        else $error("running maximum below its frame start value");

    a_store_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_en |=> $stable(t_reg))
        else $error("pixel changed during division");

endmodule

// File: dv/tfcm_colour_checker.sv
`timescale 1ns / 1ps
// tfcm_colour_checker: watches the scale register port and both pixel channels,
// predicts each RGB565 colour and frame min/max, compares results in order
// depends on tfcm_pkg only
module tfcm_colour_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic signed [tfcm_pkg::TEMP_W-1:0] temperature,
    input  logic                               frame_start,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [15:0]                        colour,
    input  logic signed [tfcm_pkg::TEMP_W-1:0] frame_low,
    input  logic signed [tfcm_pkg::TEMP_W-1:0] frame_high,
    output int                                 errors,
    output int                                 pending
);
    import tfcm_pkg::*;

    localparam longint Q16     = 65536;
    localparam longint SPAN_A  = FRAC_A;
    localparam longint SPAN_B  = FRAC_B;
    localparam longint SPAN_C  = FRAC_C;
    localparam longint SPAN_D  = FRAC_D;
    localparam longint LVL_TOP = TOP_FULL;
    localparam longint LVL_BLU = TOP_BLUE;
    localparam int     MAX_REPORTS = 100;

    typedef struct {
        logic [15:0]              colour;
        logic signed [TEMP_W-1:0] low;
        logic signed [TEMP_W-1:0] high;
    } pixel_result_t;

    pixel_result_t            expected_pixels[$];
    logic signed [TEMP_W-1:0] scale_lo;
    logic signed [TEMP_W-1:0] scale_hi;
    logic signed [TEMP_W-1:0] run_low;
    logic signed [TEMP_W-1:0] run_high;

    // floor(top * diff / den) clamped to [0, top], flat ramp gives 0
    function automatic longint ramp_level(input longint diff, input longint den,
                                          input longint top);
        longint num;
        longint d;
        longint q;
        num = diff * top;
        d   = den;
        if (d == 0)
            return 0;
        if (d < 0)
        begin
            num = -num;
            d   = -d;
        end
        if (num <= 0)
            return 0;
        q = num / d;
        return (q > top) ? top : q;
    endfunction

    function automatic logic [15:0] ironbow_rgb565(input logic signed [TEMP_W-1:0] t,
                                                   input logic signed [TEMP_W-1:0] s_lo,
                                                   input logic signed [TEMP_W-1:0] s_hi);
        longint lo;
        longint hi;
        longint span;
        longint pa;
        longint pb;
        longint pc;
        longint pd;
        longint v;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        lo   = longint'(s_lo) * Q16;
        hi   = longint'(s_hi) * Q16;
        span = longint'(s_hi) - longint'(s_lo);
        pa   = lo + span * SPAN_A;
        pb   = lo + span * SPAN_B;
        pc   = lo + span * SPAN_C;
        pd   = lo + span * SPAN_D;
        v    = longint'(t) * Q16;

        r = 8'(ramp_level(v - pb, pc - pb, LVL_TOP));

        if (v > lo && v < pa)
            g = 8'(ramp_level(v - lo, pa - lo, LVL_TOP));
        else if (v >= pa && v <= pc)
            g = TOP_FULL;
        else if (v > pc)
            g = 8'(ramp_level(v - pd, pc - pd, LVL_TOP));
        else
            g = 8'd0;

        // breakpoints are used as given, even on a reversed scale
        if (v <= pb)
            b = 8'(ramp_level(v - pb, pa - pb, LVL_TOP));
        else if (v <= pd)
            b = 8'd0;
        else
            b = 8'(ramp_level(v - pd, hi - pd, LVL_BLU));

        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        pixel_result_t got;
        if (!rst_n)
        begin
            expected_pixels.delete();
            scale_lo = SCALE_MIN_RST;
            scale_hi = SCALE_MAX_RST;
            run_low  = LOW_RESET;
            run_high = HIGH_RESET;
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.colour = colour;
                got.low    = frame_low;
                got.high   = frame_high;
                if (expected_pixels.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: transfer with nothing expected: colour %h low %0d high %0d",
                                 $time, got.colour, got.low, got.high);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.colour !== want.colour)
                    begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: colour expected %h actual %h",
                                     $time, want.colour, got.colour);
                    end
                    if (got.low !== want.low)
                    begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: frame_low expected %0d actual %0d",
                                     $time, want.low, got.low);
                    end
                    if (got.high !== want.high)
                    begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: frame_high expected %0d actual %0d",
                                     $time, want.high, got.high);
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_SCALE_MAX)
                    scale_hi = pwdata[TEMP_W-1:0];
                else
                    scale_lo = pwdata[TEMP_W-1:0];
            end

            if (in_valid && in_ready)
            begin
                // frame start clears tracking before this pixel is folded in
                if (frame_start)
                begin
                    run_low  = LOW_RESET;
                    run_high = HIGH_RESET;
                end
                if (temperature < run_low)
                    run_low = temperature;
                if (temperature > run_high)
                    run_high = temperature;
                want.colour = ironbow_rgb565(temperature, scale_lo, scale_hi);
                want.low    = run_low;
                want.high   = run_high;
                expected_pixels.push_back(want);
            end

            pending = expected_pixels.size();
        end
    end

endmodule

// File: dv/thermal_false_colour_map_tb.sv
`timescale 1ns / 1ps
// thermal_false_colour_map_tb: stimulus, scale register writes and verdict
// depends on tfcm_pkg, thermal_false_colour_map and tfcm_colour_checker
module thermal_false_colour_map_tb;
    import tfcm_pkg::*;

    localparam logic [2:0] ADDR_SCALE_MIN = {REG_SCALE_MIN, 2'b00};
    localparam logic [2:0] ADDR_SCALE_MAX = {REG_SCALE_MAX, 2'b00};
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int NUM_PHASES     = 10;
    localparam int NUM_DIRECTED   = 17;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic [2:0]               paddr       = '0;
    logic [31:0]              pwdata      = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic signed [TEMP_W-1:0] temperature = '0;
    logic                     frame_start = 1'b0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic [15:0]              colour;
    logic signed [TEMP_W-1:0] frame_low;
    logic signed [TEMP_W-1:0] frame_high;

    int errors;
    int pending;
    int idle_cycles = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    logic steady    = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    thermal_false_colour_map u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .temperature (temperature),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .colour      (colour),
        .frame_low   (frame_low),
        .frame_high  (frame_high)
    );

    tfcm_colour_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .temperature (temperature),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .colour      (colour),
        .frame_low   (frame_low),
        .frame_high  (frame_high),
        .errors      (errors),
        .pending     (pending)
    );

    task automatic reg_write(input logic [2:0] addr, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high across back-to-back pixels, dropped only for a gap
    task automatic send_pixel(input logic signed [TEMP_W-1:0] t, input logic fs);
        in_valid    <= 1'b1;
        temperature <= t;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        if (!steady && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done = holds_done + 1;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int dir_temp[NUM_DIRECTED];
        int set_lo[NUM_PHASES];
        int set_hi[NUM_PHASES];
        int set_n[NUM_PHASES];
        int frame_left;
        int a;
        int b;
        int w;
        int x;
        logic fs;
        logic signed [TEMP_W-1:0] t;

        // reset scale 320..640: extremes, both sides of each breakpoint and end
        dir_temp = '{-8192, 8191, 0, -1, 319, 320, 321, 387, 388, 421, 422,
                     455, 456, 581, 582, 640, 641};
        set_lo = '{320, 640, 500, -8192, 8191, -8192, 0, 0, 0, 0};
        set_hi = '{640, 320, 500, 8191, -8192, -8192, 1, 0, 0, 0};
        set_n  = '{60, 50, 30, 60, 40, 20, 40, 50, 50, 50};
        for (int p = 7; p < NUM_PHASES; p++)
        begin
            set_lo[p] = int'($urandom_range(5000)) - 1000;
            set_hi[p] = set_lo[p] + int'($urandom_range(1400)) - 200;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset scale, new frames in between
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_pixel(14'(dir_temp[i]), (i == 0) || (i == 4) || (i == 11));
        in_valid <= 1'b0;
        wait_drained();

        // empty scale: every breakpoint coincides, flat ramps
        reg_write(ADDR_SCALE_MIN, 500);
        reg_write(ADDR_SCALE_MAX, 500);
        send_pixel(14'sd499, 1'b1);
        send_pixel(14'sd500, 1'b0);
        send_pixel(14'sd501, 1'b0);
        in_valid <= 1'b0;
        wait_drained();

        frame_left = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            reg_write(ADDR_SCALE_MIN, set_lo[p]);
            reg_write(ADDR_SCALE_MAX, set_hi[p]);
            steady <= (p == 0);
            if (p == 1)
                holds_asked <= holds_asked + 1;
            a = (set_lo[p] < set_hi[p]) ? set_lo[p] : set_hi[p];
            b = (set_lo[p] < set_hi[p]) ? set_hi[p] : set_lo[p];
            w = (b - a) / 4 + 4;
            for (int k = 0; k < set_n[p]; k++)
            begin
                if (frame_left == 0)
                begin
                    fs = 1'b1;
                    frame_left = $urandom_range(40, 1);
                end
                else
                    fs = ($urandom_range(99) < 3);
                frame_left = frame_left - 1;
                if ($urandom_range(9) < 3)
                    t = 14'($urandom);
                else
                begin
                    // mostly around the scale so every ramp segment is hit
                    x = a - w + int'($urandom_range(b - a + 2 * w));
                    if (x < -8192)
                        x = -8192;
                    if (x > 8191)
                        x = 8191;
                    t = 14'(x);
                end
                send_pixel(t, fs);
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
